// File: sv/pattern_permutation_rank_macros.svh
// assertion macros for the pattern permutation rank block
`ifndef PATTERN_PERMUTATION_RANK_MACROS_SVH
`define PATTERN_PERMUTATION_RANK_MACROS_SVH

// same-cycle implication, checked outside reset
`define PPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pattern_permutation_rank: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pattern_permutation_rank: next-cycle check failed");

`endif

// File: sv/ppr_pkg.sv
package ppr_pkg;

    localparam int CELLS       = 16;
    localparam int MAX_PATTERN = 8;
    localparam int MAX_K       = (MAX_PATTERN < CELLS) ? MAX_PATTERN : CELLS;

    localparam int TILE_W  = 4;
    localparam int BOARD_W = 64;
    localparam int TILES_W = 32;
    localparam int SIZE_W  = 4;
    localparam int RANK_W  = 29;
    localparam int OUT_W   = ((RANK_W + 7) / 8) * 8;
    localparam int POS_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int KI_W    = $clog2(MAX_PATTERN + 1);

    localparam int STAGES  = 5;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TILES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SIZE  = 1'b1;

    localparam logic [TILES_W-1:0] TILES_RESET = 32'h7654_3210;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 4'd8;

    typedef logic [POS_W-1:0]                t_pos;
    typedef t_pos [MAX_PATTERN-1:0]          t_pos_vec;
    typedef logic [RANK_W-1:0]               t_rank;
    typedef t_rank [MAX_PATTERN-1:0]         t_rank_vec;
    typedef t_rank_vec [MAX_PATTERN:0]       t_weight_tab;
    typedef logic [KI_W-1:0]                 t_k;

    // weight of slot i for pattern size k: product of (CELLS-m), m = i+1 .. k-1
    function automatic t_weight_tab weight_table();
        t_weight_tab tab;
        longint      w;
        for (int k = 0; k <= MAX_PATTERN; k++) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                w = 1;
                for (int m = i + 1; m < k; m++) begin
                    w = (w * longint'(CELLS - m)) & ((longint'(1) << RANK_W) - 1);
                end
                tab[k][i] = (i < k) ? w[RANK_W-1:0] : '0;
            end
        end
        return tab;
    endfunction

    localparam t_weight_tab WEIGHTS = weight_table();

    function automatic t_k used_slots(input logic [SIZE_W-1:0] size);
        t_k k;
        if (int'(size) > MAX_K) begin
            k = KI_W'(MAX_K);
        end else begin
            k = size[KI_W-1:0];
        end
        return k;
    endfunction

endpackage

// File: sv/ppr_locate.sv
module ppr_locate (
    input  logic [ppr_pkg::BOARD_W-1:0] i_board,
    input  logic [ppr_pkg::TILES_W-1:0] i_tiles,
    input  ppr_pkg::t_k                 i_k,
    output ppr_pkg::t_pos_vec           o_pos
);

    // last matching cell wins, absent tile and unused slot give zero
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < ppr_pkg::MAX_PATTERN; i++) begin
            if (i < int'(i_k)) begin
                for (int c = 0; c < ppr_pkg::CELLS; c++) begin
                    if (i_board[ppr_pkg::TILE_W*c +: ppr_pkg::TILE_W] ==
                        i_tiles[ppr_pkg::TILE_W*i +: ppr_pkg::TILE_W]) begin
                        o_pos[i] = ppr_pkg::POS_W'(c);
                    end
                end
            end
        end
    end

endmodule

// File: sv/ppr_adjust.sv
module ppr_adjust (
    input  ppr_pkg::t_pos_vec i_pos,
    output ppr_pkg::t_pos_vec o_pos
);

    // each slot in order lowers the later slots that sit above it
    always_comb begin
        ppr_pkg::t_pos_vec p;
        p = i_pos;
        for (int i = 0; i < ppr_pkg::MAX_PATTERN; i++) begin
            for (int j = i + 1; j < ppr_pkg::MAX_PATTERN; j++) begin
                if (p[j] > p[i]) begin
                    p[j] = p[j] - 1'b1;
                end
            end
        end
        o_pos = p;
    end

endmodule

// File: sv/ppr_weigh.sv
module ppr_weigh (
    input  ppr_pkg::t_pos_vec  i_pos,
    input  ppr_pkg::t_k        i_k,
    output ppr_pkg::t_rank_vec o_prod
);

    always_comb begin
        for (int i = 0; i < ppr_pkg::MAX_PATTERN; i++) begin
            o_prod[i] = ppr_pkg::RANK_W'(ppr_pkg::RANK_W'(i_pos[i]) *
                                         ppr_pkg::WEIGHTS[i_k][i]);
        end
    end

endmodule

// File: sv/pattern_permutation_rank.sv
// pattern_permutation_rank: pattern-database index of a sliding-tile board
// input stream s_axis carries one board per transaction, cell c in
// tdata bits 4c+3..4c; output stream m_axis returns one rank per board,
// in order, in the low 29 bits of tdata
// configuration: i_cfg_wr_en writes i_cfg_wdata to register i_cfg_idx
// (0 pattern_tiles, 1 pattern_size); write only while the pipeline is empty
// pipeline of five registers: input, tile positions, adjusted positions,
// weighted terms, rank; a board accepted into the input register moves
// through them in that order, and the rank register drives m_axis
// throughput is one board per cycle while m_axis_tready stays high; the
// position adjust chain and the eight-term sum set the cycle time
// every stage stalls on its own: s_axis_tready stays high while any stage
// holds a bubble, so boards keep entering while a rank waits on m_axis
// reset clears all stage valids and loads tiles 0..7 with pattern size 8
`include "pattern_permutation_rank_macros.svh"

module pattern_permutation_rank (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ppr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ppr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ppr_pkg::BOARD_W-1:0]   s_axis_tdata,  // board
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ppr_pkg::OUT_W-1:0]     m_axis_tdata   // rank
);

    logic [ppr_pkg::TILES_W-1:0] r_tiles;
    logic [ppr_pkg::SIZE_W-1:0]  r_size;
    ppr_pkg::t_k                 w_k;

    logic [ppr_pkg::STAGES-1:0]  r_valid;
    logic [ppr_pkg::STAGES:0]    w_ready;

    logic [ppr_pkg::BOARD_W-1:0] r_board;
    ppr_pkg::t_pos_vec           r_pos;
    ppr_pkg::t_pos_vec           r_adj;
    ppr_pkg::t_rank_vec          r_prod;
    ppr_pkg::t_rank              r_rank;

    ppr_pkg::t_pos_vec           w_pos;
    ppr_pkg::t_pos_vec           w_adj;
    ppr_pkg::t_rank_vec          w_prod;
    ppr_pkg::t_rank              n_rank;

    assign w_k = ppr_pkg::used_slots(r_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiles <= ppr_pkg::TILES_RESET;
            r_size  <= ppr_pkg::SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                ppr_pkg::CFG_PATTERN_TILES: r_tiles <= i_cfg_wdata[ppr_pkg::TILES_W-1:0];
                ppr_pkg::CFG_PATTERN_SIZE:  r_size  <= i_cfg_wdata[ppr_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage takes new data when empty or when its successor takes its data
    always_comb begin
        w_ready[ppr_pkg::STAGES] = m_axis_tready;
        for (int s = ppr_pkg::STAGES - 1; s >= 0; s--) begin
            w_ready[s] = !r_valid[s] || w_ready[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ready[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < ppr_pkg::STAGES; s++) begin
                if (w_ready[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    ppr_locate u_locate (
        .i_board (r_board),
        .i_tiles (r_tiles),
        .i_k     (w_k),
        .o_pos   (w_pos)
    );

    ppr_adjust u_adjust (
        .i_pos (r_pos),
        .o_pos (w_adj)
    );

    ppr_weigh u_weigh (
        .i_pos  (r_adj),
        .i_k    (w_k),
        .o_prod (w_prod)
    );

    always_comb begin
        n_rank = '0;
        for (int i = 0; i < ppr_pkg::MAX_PATTERN; i++) begin
            n_rank = n_rank + r_prod[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_board <= s_axis_tdata;
        end
        if (w_ready[1]) begin
            r_pos <= w_pos;
        end
        if (w_ready[2]) begin
            r_adj <= w_adj;
        end
        if (w_ready[3]) begin
            r_prod <= w_prod;
        end
        if (w_ready[4]) begin
            r_rank <= n_rank;
        end
    end

    assign s_axis_tready = w_ready[0];
    assign m_axis_tvalid = r_valid[ppr_pkg::STAGES-1];
    assign m_axis_tdata  = {{(ppr_pkg::OUT_W - ppr_pkg::RANK_W){1'b0}}, r_rank};

    `PPR_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n, !s_axis_tready, &r_valid)
    `PPR_ASSERT_NEXT(a_accept_fills_input, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_valid[0])
    `PPR_ASSERT_NEXT(a_last_term_reaches_output, i_clk, i_rst_n, r_valid[3] && w_ready[4], m_axis_tvalid)

endmodule

// File: verif/pattern_permutation_rank_tb.sv
module pattern_permutation_rank_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 50;

    class rank_scoreboard;
        logic [ppr_pkg::TILES_W-1:0] pattern_tiles;
        logic [ppr_pkg::SIZE_W-1:0]  pattern_size;
        ppr_pkg::t_rank              rank_q[$];
        int                          errors;

        function new();
            pattern_tiles = ppr_pkg::TILES_RESET;
            pattern_size  = ppr_pkg::SIZE_RESET;
            errors        = 0;
        endfunction

        // works out the database index of one accepted board and queues it
        function void predict_rank(logic [ppr_pkg::BOARD_W-1:0] board);
            int unsigned     slots;
            int unsigned     pos[ppr_pkg::MAX_PATTERN];
            longint unsigned acc;
            longint unsigned weight;
            slots = pattern_size;
            if (slots > ppr_pkg::MAX_PATTERN) begin
                slots = ppr_pkg::MAX_PATTERN;
            end
            if (slots > ppr_pkg::CELLS) begin
                slots = ppr_pkg::CELLS;
            end
            foreach (pos[i]) begin
                pos[i] = 0;
            end
            for (int i = 0; i < slots; i++) begin
                for (int c = 0; c < ppr_pkg::CELLS; c++) begin
                    if (board[ppr_pkg::TILE_W*c +: ppr_pkg::TILE_W] ==
                        pattern_tiles[ppr_pkg::TILE_W*i +: ppr_pkg::TILE_W]) begin
                        pos[i] = c;
                    end
                end
            end
            for (int i = 0; i < slots; i++) begin
                for (int j = i + 1; j < slots; j++) begin
                    if (pos[j] > pos[i]) begin
                        pos[j] = pos[j] - 1;
                    end
                end
            end
            acc    = 0;
            weight = 1;
            for (int i = slots; i > 0; i--) begin
                acc    = acc + longint'(pos[i-1]) * weight;
                weight = weight * longint'(ppr_pkg::CELLS - (i - 1));
            end
            rank_q.insert(rank_q.size(), acc[ppr_pkg::RANK_W-1:0]);
        endfunction

        function void check_rank(ppr_pkg::t_rank got);
            ppr_pkg::t_rank want;
            if (rank_q.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("rank %0d arrived with no board outstanding", got);
                end
            end else begin
                want = rank_q.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("rank mismatch: expected %0d, actual %0d", want, got);
                    end
                end
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [ppr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [ppr_pkg::CFG_W-1:0]     i_cfg_wdata;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [ppr_pkg::BOARD_W-1:0]   s_axis_tdata;   // board
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [ppr_pkg::OUT_W-1:0]     m_axis_tdata;   // rank

    rank_scoreboard sb;
    bit             calm = 1'b0;
    int             quiet_cycles = 0;

    pattern_permutation_rank uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [ppr_pkg::BOARD_W-1:0] shuffled_board();
        logic [ppr_pkg::TILE_W-1:0]  tile_at[ppr_pkg::CELLS];
        logic [ppr_pkg::TILE_W-1:0]  t;
        logic [ppr_pkg::BOARD_W-1:0] b;
        int                          j;
        for (int i = 0; i < ppr_pkg::CELLS; i++) begin
            tile_at[i] = ppr_pkg::TILE_W'(i);
        end
        for (int i = ppr_pkg::CELLS - 1; i > 0; i--) begin
            j          = $urandom_range(0, i);
            t          = tile_at[i];
            tile_at[i] = tile_at[j];
            tile_at[j] = t;
        end
        b = '0;
        for (int i = 0; i < ppr_pkg::CELLS; i++) begin
            b[ppr_pkg::TILE_W*i +: ppr_pkg::TILE_W] = tile_at[i];
        end
        return b;
    endfunction

    task automatic write_reg(input logic [ppr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppr_pkg::CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        if (idx == ppr_pkg::CFG_PATTERN_TILES) begin
            sb.pattern_tiles = value;
        end else begin
            sb.pattern_size = value[ppr_pkg::SIZE_W-1:0];
        end
    endtask

    task automatic send_board(input logic [ppr_pkg::BOARD_W-1:0] board);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = board;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.rank_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // downstream backpressure
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_rank(m_axis_tdata[ppr_pkg::RANK_W-1:0]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.predict_rank(s_axis_tdata);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [ppr_pkg::BOARD_W-1:0] directed[8];
        logic [ppr_pkg::TILES_W-1:0] set_tiles[4];
        logic [ppr_pkg::SIZE_W-1:0]  set_size[4];
        logic [ppr_pkg::CFG_W-1:0]   wval;
        logic [ppr_pkg::BOARD_W-1:0] board;
        int                          r;
        int                          c;

        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = ppr_pkg::CFG_PATTERN_TILES;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;

        directed[0] = 64'h0000_0000_0000_0000;
        directed[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        directed[2] = 64'h0123_4567_89AB_CDEF;
        directed[3] = 64'hFEDC_BA98_7654_3210;
        directed[4] = 64'h5555_5555_AAAA_AAAA;
        directed[5] = 64'hFEDC_BA98_7654_3211;
        directed[6] = 64'h0FED_CBA9_8765_4321;
        directed[7] = shuffled_board();

        // reset values, all-ones with oversized k, empty pattern, repeated tile
        set_tiles[0] = ppr_pkg::TILES_RESET;
        set_size[0]  = ppr_pkg::SIZE_RESET;
        set_tiles[1] = 32'hFFFF_FFFF;
        set_size[1]  = 4'd15;
        set_tiles[2] = 32'h0000_0000;
        set_size[2]  = 4'd0;
        set_tiles[3] = 32'h3333_3333;
        set_size[3]  = 4'd8;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int s = 0; s < 4; s++) begin
            if (s > 0) begin
                drain();
                write_reg(ppr_pkg::CFG_PATTERN_TILES, set_tiles[s]);
                wval                      = $urandom;
                wval[ppr_pkg::SIZE_W-1:0] = set_size[s];
                write_reg(ppr_pkg::CFG_PATTERN_SIZE, wval);
            end
            for (int b = 0; b < ((s == 0) ? 8 : 5); b++) begin
                send_board(directed[b]);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            calm = (p == PHASES - 1);
            if ($urandom_range(0, 3) == 0) begin
                wval = $urandom;
            end else begin
                board = shuffled_board();
                wval  = board[ppr_pkg::TILES_W-1:0];
            end
            write_reg(ppr_pkg::CFG_PATTERN_TILES, wval);
            wval = $urandom;
            if (p == 0) begin
                wval[ppr_pkg::SIZE_W-1:0] = 4'd1;
            end else if (p == 1) begin
                wval[ppr_pkg::SIZE_W-1:0] = 4'd9;
            end else if ($urandom_range(0, 3) == 0) begin
                wval[ppr_pkg::SIZE_W-1:0] = ppr_pkg::SIZE_W'($urandom_range(0, 15));
            end else begin
                wval[ppr_pkg::SIZE_W-1:0] = ppr_pkg::SIZE_W'($urandom_range(1, 8));
            end
            write_reg(ppr_pkg::CFG_PATTERN_SIZE, wval);

            repeat (PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    board = shuffled_board();
                end else if (r == 8) begin
                    board = shuffled_board();
                    c     = $urandom_range(0, ppr_pkg::CELLS - 1);
                    board[ppr_pkg::TILE_W*c +: ppr_pkg::TILE_W] = ppr_pkg::TILE_W'($urandom);
                end else begin
                    board = {$urandom, $urandom};
                end
                send_board(board);
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.rank_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
